// ----- design/qrs_pkg.sv -----
// Shared types and constants for the quadratic root solver.
// No dependencies; qrs_front, qrs_fifo, qrs_back, the top level and the checker import it.
`default_nettype none
package qrs_pkg;
	localparam int OUT_W      = 33;
	localparam int OUT_DATA_W = 72;
	localparam int QD         = 4;
	localparam int QAW        = 2;

	typedef enum logic [1:0] {
		CASE_NONE   = 2'd0,
		CASE_DOUBLE = 2'd1,
		CASE_TWO    = 2'd2,
		CASE_LINEAR = 2'd3
	} root_case_t;

	typedef logic [QAW:0] qcount_t;
endpackage
`default_nettype wire

// ----- design/qrs_front.sv -----
// Front end: takes coefficient items, forms the discriminant and classifies.
// Depends on qrs_pkg; feeds qrs_fifo.
`default_nettype none
module qrs_front #(
	parameter int CW = 16,
	parameter int FB = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [CW-1:0]       a_in,
	input  wire logic [CW-1:0]       b_in,
	input  wire logic [CW-1:0]       c_in,
	input  wire qrs_pkg::qcount_t    q_cnt,
	output logic                     push,
	output logic [(2+(CW+1+FB)+1+(CW+1)+(2*CW+1))-1:0] entry
);
	import qrs_pkg::*;
	localparam int DW  = 2*CW + 1;
	localparam int DSW = 2*CW + 2;
	localparam int BW  = CW + 1 + FB;
	localparam int DNW = CW + 1;

	logic                 v_s1, v_s2;
	logic signed [CW-1:0] a_s1, b_s1, c_s1, a_s2, b_s2;
	logic signed [2*CW-1:0] bb_s2, ac_s2;
	logic signed [DSW-1:0] disc;
	logic signed [BW-1:0] base;
	logic [CW-1:0]        amag;
	logic [DNW-1:0]       dmag;
	root_case_t           rcase;
	logic [QAW+1:0]       claimed;

	// Items in flight ahead of the queue hold a slot so the queue never overflows.
	assign claimed  = (QAW+2)'(q_cnt) + (QAW+2)'(v_s1) + (QAW+2)'(v_s2);
	assign in_ready = claimed < (QAW+2)'(QD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= a_in;
		b_s1  <= b_in;
		c_s1  <= c_in;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		bb_s2 <= b_s1 * b_s1;
		ac_s2 <= a_s1 * c_s1;
	end

	always_comb begin
		disc = DSW'(bb_s2) - (DSW'(ac_s2) <<< 2);
		base = -(BW'(b_s2) <<< FB);
		amag = a_s2[CW-1] ? CW'(-a_s2) : CW'(a_s2);
		dmag = {amag, 1'b0};
		if (a_s2 == '0)
			rcase = CASE_LINEAR;
		else if (disc[DSW-1])
			rcase = CASE_NONE;
		else if (disc == '0)
			rcase = CASE_DOUBLE;
		else
			rcase = CASE_TWO;
	end

	assign push  = v_s2;
	assign entry = {rcase, base, a_s2[CW-1], dmag, disc[DW-1:0]};
endmodule
`default_nettype wire

// ----- design/qrs_fifo.sv -----
// Short queue between the front end and the root/divide back end.
// Depends on qrs_pkg for its depth and count type.
`default_nettype none
module qrs_fifo #(
	parameter int EW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [EW-1:0] wdata,
	input  wire logic          pop,
	output logic [EW-1:0]      rdata,
	output qrs_pkg::qcount_t   cnt
);
	import qrs_pkg::*;
	logic [EW-1:0]  mem [QD];
	logic [QAW-1:0] wp_q, rp_q;
	qcount_t        cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + qcount_t'(push) - qcount_t'(pop);
		end
	end

	assign rdata = mem[rp_q];
	assign cnt   = cnt_q;
endmodule
`default_nettype wire

// ----- design/qrs_sqrt.sv -----
// Pipelined restoring square root, one result bit per stage, with a tag that
// travels alongside. No package dependencies.
`default_nettype none
module qrs_sqrt #(
	parameter int DW  = 33,
	parameter int FB  = 16,
	parameter int TGW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [DW-1:0]  rad_in,
	input  wire logic [TGW-1:0] tag_in,
	output logic                out_valid,
	output logic [(DW+1)/2+FB-1:0] root_out,
	output logic [TGW-1:0]      tag_out
);
	localparam int SW = (DW+1)/2 + FB;
	localparam int XW = 2*SW;

	logic           v_s   [SW];
	logic [XW-1:0]  rad_s [SW];
	logic [SW-1:0]  rem_s [SW];
	logic [SW-1:0]  root_s[SW];
	logic [TGW-1:0] tag_s [SW];

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic           iv;
		logic [XW-1:0]  irad;
		logic [SW-1:0]  irem, iroot;
		logic [TGW-1:0] itag;
		logic [SW+1:0]  r2, trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign iv    = in_valid;
			assign irad  = XW'(rad_in) << (2*FB);
			assign irem  = '0;
			assign iroot = '0;
			assign itag  = tag_in;
		end else begin : g_next
			assign iv    = v_s[k-1];
			assign irad  = rad_s[k-1];
			assign irem  = rem_s[k-1];
			assign iroot = root_s[k-1];
			assign itag  = tag_s[k-1];
		end

		assign r2    = {irem, irad[XW-1:XW-2]};
		assign trial = {iroot, 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= iv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= irad << 2;
				rem_s[k]  <= ge ? SW'(r2 - trial) : SW'(r2);
				root_s[k] <= {iroot[SW-2:0], ge};
				tag_s[k]  <= itag;
			end
		end
	end

	assign out_valid = v_s[SW-1];
	assign root_out  = root_s[SW-1];
	assign tag_out   = tag_s[SW-1];
endmodule
`default_nettype wire

// ----- design/qrs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; signed numerator
// by a magnitude and sign, truncating toward zero. No package dependencies.
`default_nettype none
module qrs_div #(
	parameter int CW = 16,
	parameter int NW = 35
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [NW-1:0] num,
	input  wire logic [CW:0]          dmag,
	input  wire logic                 dneg,
	output logic [NW-2:0]             qmag,
	output logic                      qneg
);
	localparam int MW  = NW - 1;
	localparam int DNW = CW + 1;

	logic [MW-1:0]  dvd_s [MW];
	logic [MW-1:0]  quo_s [MW];
	logic [DNW-1:0] rem_s [MW];
	logic [DNW-1:0] d_s   [MW];
	logic           neg_s [MW];

	for (genvar k = 0; k < MW; k++) begin : g_stage
		logic [MW-1:0]  idvd, iquo;
		logic [DNW-1:0] irem, id;
		logic           ineg;
		logic [DNW:0]   r2;
		logic           ge;

		if (k == 0) begin : g_first
			assign idvd = num[NW-1] ? MW'(-num) : MW'(num);
			assign iquo = '0;
			assign irem = '0;
			assign id   = dmag;
			assign ineg = num[NW-1] ^ dneg;
		end else begin : g_next
			assign idvd = dvd_s[k-1];
			assign iquo = quo_s[k-1];
			assign irem = rem_s[k-1];
			assign id   = d_s[k-1];
			assign ineg = neg_s[k-1];
		end

		assign r2 = {irem, idvd[MW-1]};
		assign ge = r2 >= {1'b0, id};

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k] <= idvd << 1;
				quo_s[k] <= {iquo[MW-2:0], ge};
				rem_s[k] <= ge ? DNW'(r2 - {1'b0, id}) : DNW'(r2);
				d_s[k]   <= id;
				neg_s[k] <= ineg;
			end
		end
	end

	assign qmag = quo_s[MW-1];
	assign qneg = neg_s[MW-1];
endmodule
`default_nettype wire

// ----- design/qrs_back.sv -----
// Back end: square root, numerator forming, two dividers and the output register.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none
module qrs_back #(
	parameter int CW = 16,
	parameter int FB = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	output logic       pop,
	input  wire logic [(2+(CW+1+FB)+1+(CW+1)+(2*CW+1))-1:0] entry,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [1:0] root_case,
	output logic [qrs_pkg::OUT_W-1:0] root_plus,
	output logic [qrs_pkg::OUT_W-1:0] root_minus
);
	import qrs_pkg::*;
	localparam int DW  = 2*CW + 1;
	localparam int BW  = CW + 1 + FB;
	localparam int DNW = CW + 1;
	localparam int TGW = 2 + BW + 1 + DNW;
	localparam int SW  = (DW+1)/2 + FB;
	localparam int NW  = ((SW > BW) ? SW : BW) + 2;
	localparam int MW  = NW - 1;
	localparam int WW  = ((MW > OUT_W) ? MW : OUT_W) + 2;
	localparam logic [WW-1:0] LIM = WW'(1) << (OUT_W-1);

	logic                en;
	logic                sq_v;
	logic [SW-1:0]       sq_root;
	logic [TGW-1:0]      sq_tag;
	root_case_t          sq_case;
	logic signed [BW-1:0] sq_base;
	logic                pr_v_s, out_v_q;
	root_case_t          pr_case_s;
	logic signed [NW-1:0] nump_s, numm_s;
	logic [DNW-1:0]      dmag_s;
	logic                dneg_s;
	logic                dv_s  [MW];
	root_case_t          dc_s  [MW];
	logic [MW-1:0]       qp_mag, qm_mag;
	logic                qp_neg, qm_neg;
	logic [OUT_W-1:0]    sat_p, sat_m;
	root_case_t          case_q;
	logic [OUT_W-1:0]    plus_q, minus_q;

	// The whole back end advances together whenever the output register can move.
	assign en  = !out_v_q || out_ready;
	assign pop = en && q_valid;

	qrs_sqrt #(.DW(DW), .FB(FB), .TGW(TGW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pop),
		.rad_in(entry[DW-1:0]), .tag_in(entry[TGW+DW-1:DW]),
		.out_valid(sq_v), .root_out(sq_root), .tag_out(sq_tag)
	);

	assign sq_case = root_case_t'(sq_tag[TGW-1:TGW-2]);
	assign sq_base = sq_tag[TGW-3:DNW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pr_v_s <= 1'b0;
		else if (en)
			pr_v_s <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_case_s <= sq_case;
			nump_s    <= NW'(sq_base) + NW'({1'b0, sq_root});
			numm_s    <= NW'(sq_base) - NW'({1'b0, sq_root});
			dneg_s    <= sq_tag[DNW];
			dmag_s    <= sq_tag[DNW-1:0];
		end
	end

	qrs_div #(.CW(CW), .NW(NW)) u_div_plus (
		.clk(clk), .en(en), .num(nump_s), .dmag(dmag_s), .dneg(dneg_s),
		.qmag(qp_mag), .qneg(qp_neg)
	);

	qrs_div #(.CW(CW), .NW(NW)) u_div_minus (
		.clk(clk), .en(en), .num(numm_s), .dmag(dmag_s), .dneg(dneg_s),
		.qmag(qm_mag), .qneg(qm_neg)
	);

	for (genvar k = 0; k < MW; k++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[k] <= 1'b0;
			else if (en)
				dv_s[k] <= (k == 0) ? pr_v_s : dv_s[(k == 0) ? 0 : k-1];
		end
		always_ff @(posedge clk) begin
			if (en)
				dc_s[k] <= (k == 0) ? pr_case_s : dc_s[(k == 0) ? 0 : k-1];
		end
	end

	function automatic logic [OUT_W-1:0] saturate(input logic [MW-1:0] mag, input logic neg);
		logic [WW-1:0] m;
		logic [WW-1:0] r;
		m = WW'(mag);
		if (neg)
			r = (m > LIM) ? -LIM : -m;
		else
			r = (m >= LIM) ? LIM - WW'(1) : m;
		return r[OUT_W-1:0];
	endfunction

	assign sat_p = saturate(qp_mag, qp_neg);
	assign sat_m = saturate(qm_mag, qm_neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en)
			out_v_q <= dv_s[MW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case_q <= dc_s[MW-1];
			unique case (dc_s[MW-1])
				CASE_DOUBLE, CASE_TWO: begin
					plus_q  <= sat_p;
					minus_q <= sat_m;
				end
				CASE_NONE, CASE_LINEAR: begin
					plus_q  <= '0;
					minus_q <= '0;
				end
				default: begin
					plus_q  <= '0;
					minus_q <= '0;
				end
			endcase
		end
	end

	assign out_valid  = out_v_q;
	assign root_case  = case_q;
	assign root_plus  = plus_q;
	assign root_minus = minus_q;
endmodule
`default_nettype wire

// ----- design/quadratic_root_solver_top.sv -----
// Quadratic root solver top level: coefficient stream in, case and two roots out.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
// Accept to result: two front-end stages, the queue, S = (2*COEF_WIDTH+2)/2 +
// FRAC_BITS square-root stages, the numerator register, M divider stages and
// the output register. Throughput: one item per cycle unless the output stalls,
// as root and divider are pipelined. Reset clears all valid and queue state.
`default_nettype none
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// coef_a, coef_b, coef_c from the lowest bit up, zero padded to bytes
	input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// root_case, root_plus, root_minus from the lowest bit up, zero padded
	output logic [qrs_pkg::OUT_DATA_W-1:0] m_tdata
);
	import qrs_pkg::*;
	localparam int CW  = COEF_WIDTH;
	localparam int EW  = 2 + (CW+1+FRAC_BITS) + 1 + (CW+1) + (2*CW+1);
	localparam int PAD = OUT_DATA_W - 2 - 2*OUT_W;

	logic          push, pop;
	logic [EW-1:0] wentry, rentry;
	qcount_t       q_cnt;
	logic [1:0]    root_case;
	logic [OUT_W-1:0] root_plus, root_minus;

	qrs_front #(.CW(CW), .FB(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.a_in(s_tdata[CW-1:0]), .b_in(s_tdata[2*CW-1:CW]),
		.c_in(s_tdata[3*CW-1:2*CW]), .q_cnt(q_cnt), .push(push), .entry(wentry)
	);

	qrs_fifo #(.EW(EW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wentry),
		.pop(pop), .rdata(rentry), .cnt(q_cnt)
	);

	qrs_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_cnt != '0), .pop(pop),
		.entry(rentry), .out_valid(m_tvalid), .out_ready(m_tready),
		.root_case(root_case), .root_plus(root_plus), .root_minus(root_minus)
	);

	assign m_tdata = {PAD'(0), root_minus, root_plus, root_case};
endmodule
`default_nettype wire

// ----- design/qrs_checker.sv -----
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg for the result case codes.
`default_nettype none
module qrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);
	import qrs_pkg::*;

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == CASE_NONE || m_tdata[1:0] == CASE_LINEAR)
		|-> m_tdata[67:2] == '0)
		else $error("roots not zero for a rootless result");

	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == CASE_DOUBLE |-> m_tdata[34:2] == m_tdata[67:35])
		else $error("double root halves differ");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:68] == '0)
		else $error("result padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire

// ----- test/quadratic_root_solver_top_tb.sv -----
// Testbench for the quadratic root solver: drives coefficient items on the input
// stream and compares each result item with a local fixed-point root predictor.
// Depends on qrs_pkg and quadratic_root_solver_top.
`timescale 1ns / 100ps
module quadratic_root_solver_top_tb;
	import qrs_pkg::*;

	localparam int CW = 16;
	localparam int FB = 16;
	localparam int IN_W = ((3*CW+7)/8)*8;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [OUT_W-1:0] minus;
		logic [OUT_W-1:0] plus;
		root_case_t       rcase;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	roots_t pending_roots[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	quadratic_root_solver_top #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[quadratic_root_solver_top] ERROR");
			$finish;
		end
	end

	// Integer square root of v, truncated to FB fractional bits.
	function automatic longint unsigned disc_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned rem;
		longint unsigned trial;
		root = 0;
		rem = 0;
		for (int i = 31 + FB; i >= 0; i--) begin
			rem = (rem << 2) | ((i >= FB) ? ((v >> (2*(i-FB))) & 64'd3) : 64'd0);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic [OUT_W-1:0] clamp_root(longint v);
		longint hi;
		hi = (64'sd1 <<< (OUT_W-1)) - 1;
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v[OUT_W-1:0];
	endfunction

	function automatic roots_t solve_roots(logic signed [CW-1:0] ca, logic signed [CW-1:0] cb,
			logic signed [CW-1:0] cc);
		roots_t r;
		longint a, b, c, disc, base, den, s;
		a = ca;
		b = cb;
		c = cc;
		r = '0;
		if (a == 0) begin
			r.rcase = CASE_LINEAR;
			return r;
		end
		disc = b*b - 4*a*c;
		if (disc < 0) begin
			r.rcase = CASE_NONE;
			return r;
		end
		base = -b * (64'sd1 <<< FB);
		den = 2*a;
		if (disc == 0) begin
			r.rcase = CASE_DOUBLE;
			r.plus = clamp_root(base / den);
			r.minus = r.plus;
			return r;
		end
		s = longint'(disc_sqrt(disc));
		r.rcase = CASE_TWO;
		r.plus = clamp_root((base + s) / den);
		r.minus = clamp_root((base - s) / den);
		return r;
	endfunction

	// Valid stays high after an accepted item so that items can follow back to back.
	task automatic send_coefs(logic [CW-1:0] ca, logic [CW-1:0] cb, logic [CW-1:0] cc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({cc, cb, ca});
		pending_roots.push_back(solve_roots(ca, cb, cc));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		roots_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = roots_t'(m_tdata[OUT_W*2+1:0]);
				if (pending_roots.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = pending_roots.pop_front();
					if (got.rcase !== want.rcase || got.plus !== want.plus
							|| got.minus !== want.minus || m_tdata[OUT_DATA_W-1:2*OUT_W+2] !== '0) begin
						$display("%0t: expected case %0d plus %h minus %h, got case %0d plus %h minus %h",
							$time, want.rcase, want.plus, want.minus, got.rcase, got.plus, got.minus);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic test_directed();
		logic [CW-1:0] ext[6];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5555};
		send_coefs(16'd0, 16'd5, 16'd3);        // a is zero
		send_coefs(16'd1, 16'd2, 16'd5);        // negative discriminant
		send_coefs(16'd1, 16'hfffa, 16'd9);     // double root
		send_coefs(16'd1, 16'd0, 16'hfffe);     // two distinct irrational roots
		send_coefs(16'hffff, 16'd3, 16'd4);     // negative a
		for (int i = 0; i < 18; i++)
			send_coefs(ext[i % 6], ext[(i / 6 + i) % 6], ext[(i * 5) % 6]);
	endtask

	task automatic test_random(int n);
		logic [CW-1:0] ca, cb, cc;
		int k;
		for (int i = 0; i < n; i++) begin
			ca = CW'($urandom);
			cb = CW'($urandom);
			cc = CW'($urandom);
			case ($urandom_range(4))
				0: ca = $urandom_range(3) == 0 ? '0 : ca;
				1: begin
					// A perfect square a*(x+k)^2 makes the double root case show up often.
					ca = CW'($urandom_range(1, 7));
					k = int'($urandom_range(0, 60));
					cb = CW'(2 * int'(ca) * k);
					if ($urandom_range(1) == 1) cb = -cb;
					cc = CW'(int'(ca) * k * k);
				end
				2: begin
					ca = CW'($urandom_range(1, 7));
					cb = CW'($urandom);
					cc = CW'($urandom_range(15) - 8);
				end
				default: ;
			endcase
			send_coefs(ca, cb, cc);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 20;
		recv_stall_pct = 64;
		test_directed();
		test_random(200);
		send_idle_pct = 64;
		recv_stall_pct = 20;
		test_random(200);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(200);
		drain_results();
		if (errors == 0) $display("[quadratic_root_solver_top] OK");
		else $display("[quadratic_root_solver_top] ERROR");
		$finish;
	end
endmodule
